// ===== hw/rtl/lzss_pkg.sv =====
`default_nettype none

package lzss_pkg;

    localparam int RING_SIZE = 4096;
    localparam int RING_AW   = $clog2(RING_SIZE);
    localparam int FILL_W    = RING_AW + 1;
    localparam int MATCH_MAX = 18;
    localparam int MATCH_MIN = 3;
    localparam int LEN_W     = $clog2(MATCH_MAX + 1);
    localparam int CAP_W     = 32;
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

    localparam logic [RING_AW-1:0] WP_INIT = RING_AW'(RING_SIZE - MATCH_MAX);
    localparam logic [7:0]         SPACE   = 8'h20;

    typedef enum logic [1:0] {
        CMD_END = 2'd0,
        CMD_LIT = 2'd1,
        CMD_REF = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [7:0]         data;
        logic [RING_AW-1:0] off;
        logic [LEN_W-1:0]   len;
        logic               fin;
    } t_cmd;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       capacity_hit;
    } t_out_req;

endpackage

`default_nettype wire

// ===== hw/rtl/lzss_front.sv =====
`default_nettype none

module lzss_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  lzss_pkg::t_in_req i_in_req,
    input  wire               i_full,
    output logic              o_push,
    output lzss_pkg::t_cmd    o_cmd
);
    import lzss_pkg::*;

    logic [8:0] r_flags, n_flags;
    logic       r_phase, n_phase;
    logic [7:0] r_off_lo, n_off_lo;
    logic       accept;
    logic [7:0] b;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && !i_full;
    assign b          = i_in_req.in_byte;

    always_comb begin
        n_flags    = r_flags;
        n_phase    = r_phase;
        n_off_lo   = r_off_lo;
        o_push     = 1'b0;
        o_cmd.kind = CMD_END;
        o_cmd.data = b;
        o_cmd.off  = {b[7:4], r_off_lo};
        o_cmd.len  = LEN_W'({1'b0, b[3:0]}) + LEN_W'(MATCH_MIN);
        o_cmd.fin  = i_in_req.final_byte;
        if (accept) begin
            if (r_phase) begin
                o_cmd.kind = CMD_REF;
                o_push     = 1'b1;
                n_flags    = r_flags >> 1;
                n_phase    = 1'b0;
            end else if (r_flags[8:1] == '0) begin
                n_flags = {1'b1, b};
                o_push  = i_in_req.final_byte;
            end else if (r_flags[0]) begin
                o_cmd.kind = CMD_LIT;
                o_push     = 1'b1;
                n_flags    = r_flags >> 1;
            end else begin
                n_off_lo = b;
                n_phase  = 1'b1;
                o_push   = i_in_req.final_byte;
            end
            if (i_in_req.final_byte) begin
                n_flags = '0;
                n_phase = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_phase <= 1'b0;
        end else begin
            r_flags <= n_flags;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_off_lo <= n_off_lo;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lzss_cmd_fifo.sv =====
`default_nettype none

module lzss_cmd_fifo (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  lzss_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  wire            i_pop,
    output lzss_pkg::t_cmd o_cmd,
    output logic           o_empty
);
    import lzss_pkg::*;

    t_cmd                 r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]   r_wr, r_rd;
    logic [CMDQ_AW:0]     r_cnt;
    logic                 do_push, do_pop;

    assign o_full  = (r_cnt == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_cmd;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lzss_back.sv =====
`default_nettype none

module lzss_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire  [31:0]        i_capacity,
    input  lzss_pkg::t_cmd     i_cmd,
    input  wire                i_cmd_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output lzss_pkg::t_out_req o_out_req
);
    import lzss_pkg::*;

    logic [7:0]         r_ring [RING_SIZE];
    logic [7:0]         r_q;

    // issue stage
    logic               r_a_valid;
    t_cmd_kind          r_a_kind;
    logic [RING_AW-1:0] r_a_src;
    logic [LEN_W-1:0]   r_a_rem;
    logic [7:0]         r_a_data;
    logic               r_a_fin;

    // write/emit stage
    logic               r_b_valid;
    logic               r_b_emit;
    logic               r_b_use_q;
    logic [7:0]         r_b_data;
    logic               r_b_last;
    logic               r_b_fin;

    logic [RING_AW-1:0] r_wp;
    logic [FILL_W-1:0]  r_fill;
    logic [CAP_W-1:0]   r_count;
    logic               r_stopped;

    logic               r_out_valid;
    t_out_req           r_out;

    logic               adv, a_ref, a_issue, a_last, a_done, load_ok;
    logic               b_go, b_we, can_emit, hit, bypass, fvalid, rd_en;
    logic [7:0]         b_byte;
    logic [RING_AW-1:0] rel;
    logic [CAP_W-1:0]   n_count;

    assign adv      = !r_out_valid || i_out_ready;
    assign a_ref    = (r_a_kind == CMD_REF);
    assign a_issue  = r_a_valid && adv;
    assign a_last   = !a_ref || (r_a_rem == LEN_W'(1));
    assign a_done   = a_issue && a_last;
    assign load_ok  = (!r_a_valid || a_done) && !(a_done && r_a_fin);
    assign o_pop    = load_ok && !i_cmd_empty;

    assign b_byte   = r_b_use_q ? r_q : r_b_data;
    assign can_emit = !r_stopped && (r_count < i_capacity);
    assign b_go     = adv && r_b_valid;
    assign b_we     = b_go && r_b_emit && can_emit;
    assign n_count  = r_count + CAP_W'(1);
    assign hit      = (n_count == i_capacity);

    // a stream end still in the emit stage makes the ring read as empty for the next issue
    assign rel      = r_a_src - WP_INIT;
    assign fvalid   = !(r_b_valid && r_b_fin) && ({1'b0, rel} < r_fill);
    assign bypass   = b_we && !r_b_fin && (r_a_src == r_wp);
    assign rd_en    = a_issue && a_ref;

    always_ff @(posedge i_clk) begin
        if (b_we) r_ring[r_wp] <= b_byte;
        if (rd_en) r_q <= r_ring[r_a_src];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_pop) begin
            r_a_valid <= 1'b1;
        end else if (a_done) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_kind <= i_cmd.kind;
            r_a_src  <= i_cmd.off;
            r_a_rem  <= i_cmd.len;
            r_a_data <= i_cmd.data;
            r_a_fin  <= i_cmd.fin;
        end else if (rd_en) begin
            r_a_src <= r_a_src + 1'b1;
            r_a_rem <= r_a_rem - LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_emit  <= (r_a_kind != CMD_END);
            r_b_use_q <= a_ref && fvalid && !bypass;
            r_b_last  <= a_last;
            r_b_fin   <= r_a_fin && a_last;
            if (r_a_kind == CMD_LIT) r_b_data <= r_a_data;
            else if (bypass)         r_b_data <= b_byte;
            else                     r_b_data <= SPACE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= WP_INIT;
            r_fill    <= '0;
            r_count   <= '0;
            r_stopped <= 1'b0;
        end else if (b_go) begin
            if (r_b_fin) begin
                r_wp      <= WP_INIT;
                r_fill    <= '0;
                r_count   <= '0;
                r_stopped <= 1'b0;
            end else if (b_we) begin
                r_wp    <= r_wp + 1'b1;
                r_count <= n_count;
                if (r_fill != FILL_W'(RING_SIZE)) r_fill <= r_fill + 1'b1;
                if (hit) r_stopped <= 1'b1;
            end else if (r_b_emit) begin
                r_stopped <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= b_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            r_out.out_byte     <= b_byte;
            r_out.run_last     <= r_b_last || hit;
            r_out.capacity_hit <= hit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/lzss_stream_decoder.sv =====
// A literal request passes through the command FIFO, the issue stage, the write/emit
// stage and the output register. Throughput: one output byte per cycle while the output
// is ready; a back-reference of 3 to 18 bytes reads the history ring once per byte.
// No command loads as a stream end completes; bytes that cause no output need only FIFO room.
// Reset: synchronous, active low; the ring needs no clearing pass (a fill count
// marks written entries) and the capacity register returns to all ones.
`default_nettype none

module lzss_stream_decoder (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  lzss_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output lzss_pkg::t_out_req o_out_req,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire  [31:0]        i_cfg_data
);
    import lzss_pkg::*;

    logic [CAP_W-1:0] r_capacity;
    logic             push, full, pop, empty;
    t_cmd             cmd_in, cmd_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '1;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    lzss_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (i_in_req),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (cmd_in)
    );

    lzss_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (cmd_out),
        .o_empty (empty)
    );

    lzss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_capacity  (r_capacity),
        .i_cmd       (cmd_out),
        .i_cmd_empty (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req)
    );

endmodule

`default_nettype wire
